[rtl/grs_pkg.sv]
// Shared types and constants for the group reverse stream block.
// No dependencies; every other file imports this package.
`default_nettype none

package grs_pkg;

    localparam int GS_W  = 5;
    localparam int CNT_W = 7;
    localparam int DATA_W = 32;

    localparam logic [GS_W-1:0] GROUP_SIZE_RESET = 5'd2;
    localparam logic            REG_GROUP_SIZE   = 1'b0;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
    } in_beat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic                     run_last;
        logic                     stream_last;
    } out_beat_t;

    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             rev;
        logic             last;
    } job_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } bank_rel_t;

endpackage

`default_nettype wire

[rtl/group_reverse_stream_core.sv]
// Top level of the group reverse stream block: config register and part wiring.
// Depends on grs_pkg, grs_front, grs_jobq, grs_store and grs_back.
//
// Values enter one beat per cycle and are written into one of two banks of a
// store of 2 x MAX_GROUP words. A group of group_size values (clamped to
// MAX_GROUP) leaves reversed, and a partial group closed by is_last leaves in
// arrival order; group_size 0 or 1 passes each value through. The front end
// fills one bank while the drain engine empties the other through the store's
// single read port at one value per cycle while the result queue has room. The
// first result of a group passes through the job queue, the drain job register,
// the store's read register and the result queue when the drain engine is free.
// Input stalls only while both banks are held.
// Writing group_size drops any partial group; write it only while idle.
`default_nettype none

module group_reverse_stream_core
    import grs_pkg::*;
#(
    parameter int MAX_GROUP = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready,
    input  wire in_beat_t    item,
    input  wire logic        push,
    output      logic        full,
    output      out_beat_t   result,
    output      logic        empty,
    input  wire logic        pop
);

    localparam int AW = $clog2(MAX_GROUP);

    logic [GS_W-1:0] group_size_reg, group_size_next;
    logic            cfg_hit;
    logic            cfg_clr;

    logic            jq_push;
    logic            jq_full;
    logic            jq_pop;
    logic            jq_empty;
    job_t            jq_in;
    job_t            jq_out;
    bank_rel_t       rel;

    logic              wr_en;
    logic [AW:0]       wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [AW:0]       rd_addr;
    logic [DATA_W-1:0] rd_data;

    always_comb
    begin
        cfg_hit         = (paddr[2] == REG_GROUP_SIZE);
        cfg_clr         = psel && penable && pwrite && cfg_hit;
        group_size_next = cfg_clr ? pwdata[GS_W-1:0] : group_size_reg;
        prdata          = cfg_hit ? {{(32-GS_W){1'b0}}, group_size_reg} : 32'd0;
        pready          = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= GROUP_SIZE_RESET;
        end
        else
        begin
            group_size_reg <= group_size_next;
        end
    end

    grs_front #(
        .MAX_GROUP (MAX_GROUP)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .group_size (group_size_reg),
        .cfg_clr    (cfg_clr),
        .item       (item),
        .push       (push),
        .full       (full),
        .jq_full    (jq_full),
        .jq_push    (jq_push),
        .jq_job     (jq_in),
        .rel        (rel),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    grs_jobq u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (jq_push),
        .job_in  (jq_in),
        .full    (jq_full),
        .pop     (jq_pop),
        .job_out (jq_out),
        .empty   (jq_empty)
    );

    grs_store #(
        .AW (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    grs_back #(
        .MAX_GROUP (MAX_GROUP)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .jq_empty (jq_empty),
        .jq_job   (jq_out),
        .jq_pop   (jq_pop),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .rel      (rel),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

endmodule

`default_nettype wire

[rtl/grs_store.sv]
// Two-bank value store: one write port, one registered read port.
// Depends on grs_pkg for the data width.
`default_nettype none

module grs_store
    import grs_pkg::*;
#(
    parameter int AW = 4
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW:0]       wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW:0]       rd_addr,
    output      logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**(AW+1)];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/grs_front.sv]
// Front end: accepts input beats, fills the current bank, issues drain jobs.
// Depends on grs_pkg; writes grs_store and feeds grs_jobq.
`default_nettype none

module grs_front
    import grs_pkg::*;
#(
    parameter int MAX_GROUP = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [GS_W-1:0]             group_size,
    input  wire logic                        cfg_clr,
    input  wire in_beat_t                    item,
    input  wire logic                        push,
    output      logic                        full,
    input  wire logic                        jq_full,
    output      logic                        jq_push,
    output      job_t                        jq_job,
    input  wire bank_rel_t                   rel,
    output      logic                        wr_en,
    output      logic [$clog2(MAX_GROUP):0]  wr_addr,
    output      logic [DATA_W-1:0]           wr_data
);

    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int AW = $clog2(MAX_GROUP);
    localparam int GW = (CW > GS_W) ? CW : GS_W;

    logic [CW-1:0] fill_reg, fill_next;
    logic          wr_bank_reg, wr_bank_next;
    logic [1:0]    busy_reg, busy_next;

    logic [GW-1:0] k_wide;
    logic [CW-1:0] k;
    logic [CW-1:0] n;
    logic          pass;
    logic          grp_full;
    logic          accept;
    logic          issue;

    always_comb
    begin
        k_wide = (GW'(group_size) > GW'(MAX_GROUP)) ? GW'(MAX_GROUP) : GW'(group_size);
        k        = k_wide[CW-1:0];
        n        = fill_reg + CW'(1);
        pass     = (k <= CW'(1));
        grp_full = (n == k);
        full     = busy_reg[wr_bank_reg] || jq_full;
        accept   = push && !full;
        issue    = accept && (pass || grp_full || item.is_last);
    end

    always_comb
    begin
        fill_next    = fill_reg;
        wr_bank_next = wr_bank_reg;
        busy_next    = busy_reg;
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (cfg_clr)
        begin
            fill_next = '0;
        end
        else if (accept)
        begin
            if (issue)
            begin
                fill_next              = '0;
                wr_bank_next           = !wr_bank_reg;
                busy_next[wr_bank_reg] = 1'b1;
            end
            else
            begin
                fill_next = n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            wr_bank_reg <= 1'b0;
            busy_reg    <= '0;
        end
        else
        begin
            fill_reg    <= fill_next;
            wr_bank_reg <= wr_bank_next;
            busy_reg    <= busy_next;
        end
    end

    assign wr_en   = accept;
    assign wr_addr = {wr_bank_reg, fill_reg[AW-1:0]};
    assign wr_data = item.value;

    assign jq_push      = issue;
    assign jq_job.bank  = wr_bank_reg;
    assign jq_job.count = CNT_W'(n);
    assign jq_job.rev   = grp_full;
    assign jq_job.last  = item.is_last;

endmodule

`default_nettype wire

[rtl/grs_jobq.sv]
// Two-entry job queue between the front end and the drain engine.
// Depends on grs_pkg for the job descriptor.
`default_nettype none

module grs_jobq
    import grs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t job_in,
    output      logic full,
    input  wire logic pop,
    output      job_t job_out,
    output      logic empty
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        full        = (cnt_reg == 2'd2);
        empty       = (cnt_reg == 2'd0);
        do_push     = push && !full;
        do_pop      = pop && !empty;
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

    assign job_out = slot_reg[rd_ptr_reg];

endmodule

`default_nettype wire

[rtl/grs_back.sv]
// Drain engine: walks one bank per job, forward or reversed, into a result queue.
// Depends on grs_pkg; reads grs_store and pops grs_jobq.
`default_nettype none

module grs_back
    import grs_pkg::*;
#(
    parameter int MAX_GROUP = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        jq_empty,
    input  wire job_t                        jq_job,
    output      logic                        jq_pop,
    output      logic                        rd_en,
    output      logic [$clog2(MAX_GROUP):0]  rd_addr,
    input  wire logic [DATA_W-1:0]           rd_data,
    output      bank_rel_t                   rel,
    output      out_beat_t                   result,
    output      logic                        empty,
    input  wire logic                        pop
);

    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int AW = $clog2(MAX_GROUP);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic          state_reg, state_next;
    job_t          job_reg, job_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          pend_reg;
    logic          rl_reg;
    logic          sl_reg;

    out_beat_t     ofifo_reg [2];
    logic          owr_ptr_reg, owr_ptr_next;
    logic          ord_ptr_reg, ord_ptr_next;
    logic [1:0]    ocnt_reg, ocnt_next;

    logic [CW-1:0] cnt;
    logic [CW-1:0] rd_idx;
    logic          last_idx;
    logic          pop_now;
    logic [2:0]    credit;
    logic          issue;
    logic          finish;

    always_comb
    begin
        cnt      = job_reg.count[CW-1:0];
        last_idx = (idx_reg == cnt - CW'(1));
        pop_now  = pop && (ocnt_reg != 2'd0);
        credit   = {1'b0, ocnt_reg} + {2'b0, pend_reg} - {2'b0, pop_now};
        issue    = (state_reg == ST_DRAIN) && (credit < 3'd2);
        finish   = issue && last_idx;
        jq_pop   = !jq_empty && ((state_reg == ST_IDLE) || finish);
        rd_idx   = job_reg.rev ? (cnt - CW'(1) - idx_reg) : idx_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (jq_pop)
                begin
                    state_next = ST_DRAIN;
                    job_next   = jq_job;
                    idx_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                if (jq_pop)
                begin
                    job_next = jq_job;
                    idx_next = '0;
                end
                else if (finish)
                begin
                    state_next = ST_IDLE;
                end
                else if (issue)
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        owr_ptr_next = pend_reg ? !owr_ptr_reg : owr_ptr_reg;
        ord_ptr_next = pop_now ? !ord_ptr_reg : ord_ptr_reg;
        ocnt_next    = ocnt_reg + {1'b0, pend_reg} - {1'b0, pop_now};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            owr_ptr_reg <= 1'b0;
            ord_ptr_reg <= 1'b0;
            ocnt_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            pend_reg    <= issue;
            owr_ptr_reg <= owr_ptr_next;
            ord_ptr_reg <= ord_ptr_next;
            ocnt_reg    <= ocnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        rl_reg  <= last_idx;
        sl_reg  <= last_idx && job_reg.last;
        if (pend_reg)
        begin
            ofifo_reg[owr_ptr_reg] <= '{value_out: rd_data, run_last: rl_reg,
                                        stream_last: sl_reg};
        end
    end

    assign rd_en     = issue;
    assign rd_addr   = {job_reg.bank, rd_idx[AW-1:0]};
    assign rel.valid = finish;
    assign rel.bank  = job_reg.bank;
    assign result    = ofifo_reg[ord_ptr_reg];
    assign empty     = (ocnt_reg == 2'd0);

endmodule

`default_nettype wire

[rtl/grs_checker.sv]
// Port-level checks for group_reverse_stream_core, bound onto the top level.
// Depends on grs_pkg for the beat types.
`default_nettype none

module grs_checker
    import grs_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready,
    input wire out_beat_t   result,
    input wire logic        empty,
    input wire logic        pop
);

    // hold a stalled result beat
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result beat changed while stalled");

    a_stream_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.stream_last) |-> result.run_last)
        else $error("stream_last without run_last");

    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[2] == REG_GROUP_SIZE))
        |=> (paddr[2] != REG_GROUP_SIZE)
            || (prdata[GS_W-1:0] == $past(pwdata[GS_W-1:0])))
        else $error("group_size readback mismatch");

endmodule

bind group_reverse_stream_core grs_checker u_grs_checker (.*);

`default_nettype wire
